>>> rtl/core/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Types, constants and helpers shared by the rotation matrix to euler cells.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int ELEM_W   = 32;      // matrix element width, Q2.30
    localparam int SQ_W     = 64;      // radicand width
    localparam int SQ_STEPS = 32;      // one result bit per sqrt cell
    localparam int SY_W     = 32;      // root width
    localparam int THR_W    = 31;
    localparam int XY_W     = 36;      // cordic vector width
    localparam int Z_W      = 34;      // binary angle accumulator width
    localparam int ANG_W    = 17;      // output angle width
    localparam int SCALE_W  = 18;
    localparam int PROD_W   = Z_W + SCALE_W;
    localparam int TABLE_N  = 32;

    localparam logic signed [ANG_W-1:0]   DEG_HALF    = 17'sd46080;
    localparam logic signed [ANG_W-1:0]   DEG_QUARTER = 17'sd23040;
    localparam logic signed [SCALE_W-1:0] DEG_SCALE   = 18'sd92160;
    localparam logic [THR_W-1:0]          THR_RESET   = 31'd1074;

    // atan(2^-i) with one full turn = 2^32
    localparam logic [31:0] ATAN_TURN [TABLE_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [2:0] {
        SP_NONE  = 3'd0,
        SP_ZERO  = 3'd1,
        SP_HALF  = 3'd2,
        SP_POS90 = 3'd3,
        SP_NEG90 = 3'd4
    } spec_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r22;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r00;
    } mat_t;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] r;
        mat_t            mat;
    } sq_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        spec_t                  spec;
    } vec_t;

    typedef struct packed {
        vec_t roll;
        vec_t pitch;
        vec_t yaw;
        logic lock;
    } cstate_t;

    // special cases and half-turn pre-rotation ahead of the cordic chain
    function automatic vec_t cordic_prep(logic signed [XY_W-1:0] y,
                                         logic signed [XY_W-1:0] x);
        vec_t v;
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        v.spec = SP_NONE;
        if (y == '0) begin
            v.spec = (x < 0) ? SP_HALF : SP_ZERO;
        end else if (x == '0) begin
            v.spec = (y > 0) ? SP_POS90 : SP_NEG90;
        end
        if (x < 0) begin
            v.z = (y >= 0) ? Z_W'(64'sh80000000) : -Z_W'(64'sh80000000);
            v.x = -x;
            v.y = -y;
        end
        return v;
    endfunction

endpackage

>>> rtl/core/rme_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One digit step of the integer square root, carrying the matrix alongside.
// ----------------------------------------------------------------------------
module rme_sqrt_cell
    import rme_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  sq_t  in_data,
    output logic out_valid,
    output sq_t  out_data
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * STEP);

    logic        valid_reg;
    sq_t         data_reg;
    sq_t         data_next;
    logic [SQ_W:0] trial;

    always_comb begin
        trial     = {1'b0, in_data.r} + {1'b0, BIT};
        data_next = in_data;
        if ({1'b0, in_data.n} >= trial) begin
            data_next.n = in_data.n - trial[SQ_W-1:0];
            data_next.r = (in_data.r >> 1) + BIT;
        end else begin
            data_next.r = in_data.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/rme_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring cordic iteration applied to the roll, pitch and yaw vectors.
// ----------------------------------------------------------------------------
module rme_cordic_cell
    import rme_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  cstate_t in_data,
    output logic    out_valid,
    output cstate_t out_data
);

    localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TURN[STAGE]);

    logic    valid_reg;
    cstate_t data_reg;
    cstate_t data_next;

    function automatic vec_t step(vec_t v);
        vec_t o;
        o = v;
        if (v.y >= 0) begin
            o.x = v.x + (v.y >>> STAGE);
            o.y = v.y - (v.x >>> STAGE);
            o.z = v.z + ANG;
        end else begin
            o.x = v.x - (v.y >>> STAGE);
            o.y = v.y + (v.x >>> STAGE);
            o.z = v.z - ANG;
        end
        return o;
    endfunction

    always_comb begin
        data_next       = in_data;
        data_next.roll  = step(in_data.roll);
        data_next.pitch = step(in_data.pitch);
        data_next.yaw   = step(in_data.yaw);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/rme_angle_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_angle_out
// Scales binary angles to 1/256 degree, applies special cases, output register.
// ----------------------------------------------------------------------------
module rme_angle_out
    import rme_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  cstate_t                 in_data,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] roll_angle,
    output logic signed [ANG_W-1:0] pitch_angle,
    output logic signed [ANG_W-1:0] yaw_angle,
    output logic                    gimbal_lock
);

    logic                     mul_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    spec_t                    spec_reg [3];
    logic                     lock_reg;

    logic                     out_valid_reg;
    logic signed [ANG_W-1:0]  ang_reg [3];
    logic                     out_lock_reg;

    function automatic logic signed [ANG_W-1:0] finish(logic signed [PROD_W-1:0] p,
                                                       spec_t s);
        logic signed [PROD_W:0]     sum;
        logic signed [PROD_W-32:0]  d;
        logic signed [ANG_W-1:0]    r;
        sum = {p[PROD_W-1], p} + (PROD_W+1)'(64'sh80000000);
        d   = sum[PROD_W:32];
        if (d > (PROD_W-31)'(DEG_HALF)) begin
            r = DEG_HALF;
        end else if (d < -(PROD_W-31)'(DEG_HALF)) begin
            r = -DEG_HALF;
        end else begin
            r = d[ANG_W-1:0];
        end
        case (s)
            SP_ZERO:  r = '0;
            SP_HALF:  r = DEG_HALF;
            SP_POS90: r = DEG_QUARTER;
            SP_NEG90: r = -DEG_QUARTER;
            default:  r = r;
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0]  <= PROD_W'(in_data.roll.z * DEG_SCALE);
            prod_reg[1]  <= PROD_W'(in_data.pitch.z * DEG_SCALE);
            prod_reg[2]  <= PROD_W'(in_data.yaw.z * DEG_SCALE);
            spec_reg[0]  <= in_data.roll.spec;
            spec_reg[1]  <= in_data.pitch.spec;
            spec_reg[2]  <= in_data.yaw.spec;
            lock_reg     <= in_data.lock;
            ang_reg[0]   <= finish(prod_reg[0], spec_reg[0]);
            ang_reg[1]   <= finish(prod_reg[1], spec_reg[1]);
            ang_reg[2]   <= finish(prod_reg[2], spec_reg[2]);
            out_lock_reg <= lock_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = ang_reg[0];
    assign pitch_angle = ang_reg[1];
    assign yaw_angle   = ang_reg[2];
    assign gimbal_lock = out_lock_reg;

endmodule

>>> rtl/core/rotation_matrix_to_euler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// Rotation matrix to x-y-z euler angles: square root and cordic cell chains.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         r00 r10 r20 r21 r22 r11 r12, Q2.30
//  m_*       out        roll pitch yaw (1/256 deg) in tdata, gimbal lock in tuser
//  cfg_*     in         singular threshold, Q2.30
//
//  one request per cycle unless m_tready stalls; the pipeline length is set by the
//  32 square root cells and the cordic cells
//  reset (aresetn low) empties the pipeline and loads the threshold default
//  a stalled m_tready freezes the whole pipeline and drops s_tready
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler
    import rme_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [223:0]     s_tdata,   // r00, r10, r20, r21, r22, r11, r12
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic             m_tuser,   // gimbal_lock
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    logic             en;
    logic [THR_W-1:0] thr_reg;

    logic             v0_reg;
    mat_t             mat0_reg;
    logic             v1_reg;
    mat_t             mat1_reg;
    logic [SQ_W-1:0]  sq0_reg;
    logic [SQ_W-1:0]  sq1_reg;
    logic             v2_reg;
    sq_t              sq2_reg;
    logic [ELEM_W-1:0] a0;
    logic [ELEM_W-1:0] a1;

    logic             sq_valid [SQ_STEPS+1];
    sq_t              sq_data  [SQ_STEPS+1];

    logic             vp_reg;
    cstate_t          cp_reg;
    cstate_t          cp_next;
    logic [SY_W-1:0]  sy;
    logic             lock;

    logic             c_valid [CORDIC_STAGES+1];
    cstate_t          c_data  [CORDIC_STAGES+1];

    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] yaw_angle;
    logic                    gimbal_lock;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // input register, squares, sum
    assign a0 = mat0_reg.r00[ELEM_W-1] ? ELEM_W'(-mat0_reg.r00) : mat0_reg.r00;
    assign a1 = mat0_reg.r10[ELEM_W-1] ? ELEM_W'(-mat0_reg.r10) : mat0_reg.r10;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vp_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vp_reg <= sq_valid[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat0_reg    <= mat_t'({s_tdata[223:192], s_tdata[191:160], s_tdata[159:128],
                                   s_tdata[127:96], s_tdata[95:64], s_tdata[63:32],
                                   s_tdata[31:0]});
            mat1_reg    <= mat0_reg;
            sq0_reg     <= SQ_W'(a0) * SQ_W'(a0);
            sq1_reg     <= SQ_W'(a1) * SQ_W'(a1);
            sq2_reg.n   <= sq0_reg + sq1_reg;
            sq2_reg.r   <= '0;
            sq2_reg.mat <= mat1_reg;
            cp_reg      <= cp_next;
        end
    end

    assign sq_valid[0] = v2_reg;
    assign sq_data[0]  = sq2_reg;

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        rme_sqrt_cell #(.STEP(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    // threshold compare and cordic set-up
    always_comb begin
        mat_t m;
        m     = sq_data[SQ_STEPS].mat;
        sy    = sq_data[SQ_STEPS].r[SY_W-1:0];
        lock  = {1'b0, sy} < {2'b0, thr_reg};
        cp_next.lock  = lock;
        cp_next.pitch = cordic_prep(-XY_W'(m.r20), XY_W'({1'b0, sy}));
        if (lock) begin
            cp_next.roll = cordic_prep(-XY_W'(m.r12), XY_W'(m.r11));
            cp_next.yaw  = cordic_prep('0, '0);
        end else begin
            cp_next.roll = cordic_prep(XY_W'(m.r21), XY_W'(m.r22));
            cp_next.yaw  = cordic_prep(XY_W'(m.r10), XY_W'(m.r00));
        end
    end

    assign c_valid[0] = vp_reg;
    assign c_data[0]  = cp_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        rme_cordic_cell #(.STAGE(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_data   (c_data[i]),
            .out_valid (c_valid[i+1]),
            .out_data  (c_data[i+1])
        );
    end

    rme_angle_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (c_valid[CORDIC_STAGES]),
        .in_data     (c_data[CORDIC_STAGES]),
        .out_valid   (m_tvalid),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .gimbal_lock (gimbal_lock)
    );

    assign m_tdata = {5'b0, yaw_angle, pitch_angle, roll_angle};
    assign m_tuser = gimbal_lock;

    a_yaw_zero_on_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> yaw_angle == '0)
        else $error("yaw not zero under gimbal lock");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> roll_angle <= DEG_HALF && roll_angle >= -DEG_HALF)
        else $error("roll out of range");

    a_pitch_half_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pitch_angle <= DEG_QUARTER + 17'sd256 &&
                     pitch_angle >= -DEG_QUARTER - 17'sd256)
        else $error("pitch outside right half plane");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vp_reg) && $stable(v2_reg))
        else $error("pipeline moved during stall");

endmodule
